[rtl/core/xcrc_pkg.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver package
// Shared constants, types and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package xcrc_pkg;

	// protocol bytes
	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_STX = 8'h02;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CAN = 8'h18;
	localparam logic [7:0] B_C   = 8'h43;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam logic [10:0] SHORT_BYTES = 11'd128;
	localparam logic [10:0] LONG_BYTES  = 11'd1024;

	// input functions
	localparam logic [1:0] FN_BYTE  = 2'd0;
	localparam logic [1:0] FN_TICK  = 2'd1;
	localparam logic [1:0] FN_START = 2'd2;
	localparam logic [1:0] FN_WFAIL = 2'd3;

	// session status
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_START  = 3'd1;
	localparam logic [2:0] ST_RETRY  = 3'd2;
	localparam logic [2:0] ST_CANCEL = 3'd3;
	localparam logic [2:0] ST_ORDER  = 3'd4;
	localparam logic [2:0] ST_WFAIL  = 3'd5;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TMO    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_QUIET       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ATT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM   = 3'd4;
	localparam int CFG_DATA_W = 24;

	localparam logic [23:0] RST_IMAGE_LIMIT = 24'd98304;
	localparam logic [15:0] RST_BYTE_TMO    = 16'd1000;
	localparam logic [15:0] RST_QUIET       = 16'd50;
	localparam logic [7:0]  RST_START_ATT   = 8'd60;
	localparam logic [7:0]  RST_RETRY_LIM   = 8'd10;

	typedef enum logic [7:0] {
		PH_HEADER = 8'b0000_0001,
		PH_BLK    = 8'b0000_0010,
		PH_NBLK   = 8'b0000_0100,
		PH_DATA   = 8'b0000_1000,
		PH_CRCH   = 8'b0001_0000,
		PH_CRCL   = 8'b0010_0000,
		PH_DRAIN  = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [23:0] image_limit;
		logic [15:0] byte_timeout_ms;
		logic [15:0] quiet_ms;
		logic [7:0]  start_attempts;
		logic [7:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic        send_valid;
		logic [7:0]  send_byte;
		logic        data_valid;
		logic [7:0]  data_byte;
		logic [9:0]  data_index;
		logic        block_good;
		logic [23:0] image_offset;
		logic [10:0] block_bytes;
		logic        done_res;
		logic [2:0]  status;
		logic        last;
	} res_t;

	// results produced by one item, handed to the result queue
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[rtl/core/xcrc_if.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver channels
// Valid/ready interfaces for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcrc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface xcrc_res_if;
	logic        valid;
	logic        ready;
	logic        send_valid;
	logic [7:0]  send_byte;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic [9:0]  data_index;
	logic        block_good;
	logic [23:0] image_offset;
	logic [10:0] block_bytes;
	logic        done_res;
	logic [2:0]  status;
	logic        last;

	modport source (output valid, output send_valid, output send_byte, output data_valid,
		output data_byte, output data_index, output block_good, output image_offset,
		output block_bytes, output done_res, output status, output last, input ready);
	modport sink (input valid, input send_valid, input send_byte, input data_valid,
		input data_byte, input data_index, input block_good, input image_offset,
		input block_bytes, input done_res, input status, input last, output ready);
	modport monitor (input valid, input send_valid, input send_byte, input data_valid,
		input data_byte, input data_index, input block_good, input image_offset,
		input block_bytes, input done_res, input status, input last, input ready);
endinterface

`default_nettype wire

[rtl/core/xcrc_cfg.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC configuration registers
// Write-only register file holding limits and timeouts.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_cfg
	import xcrc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_limit     <= RST_IMAGE_LIMIT;
			cfg_q.byte_timeout_ms <= RST_BYTE_TMO;
			cfg_q.quiet_ms        <= RST_QUIET;
			cfg_q.start_attempts  <= RST_START_ATT;
			cfg_q.retry_limit     <= RST_RETRY_LIM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_LIMIT: cfg_q.image_limit     <= cfg_wdata[23:0];
				CFG_BYTE_TMO:    cfg_q.byte_timeout_ms <= cfg_wdata[15:0];
				CFG_QUIET:       cfg_q.quiet_ms        <= cfg_wdata[15:0];
				CFG_START_ATT:   cfg_q.start_attempts  <= cfg_wdata[7:0];
				CFG_RETRY_LIM:   cfg_q.retry_limit     <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/core/xcrc_core.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC protocol core
// Input register, packet parser state and per-item result generation.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_core
	import xcrc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  cfg_t       cfg,
	xcrc_in_if.sink    item,
	input  wire logic  space,
	output push_t      push
);

	logic       valid_s1;
	logic [1:0] func_s1;
	logic [7:0] byte_s1;
	logic       advance;

	phase_t      phase_q, phase_n;
	logic        started_q, started_n;
	logic [7:0]  expected_q, expected_n;
	logic [7:0]  block_q, block_n;
	logic        long_q, long_n;
	logic [10:0] count_q, count_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  crch_q, crch_n;
	logic [15:0] idle_q, idle_n;
	logic [7:0]  start_q, start_n;
	logic [7:0]  retry_q, retry_n;
	logic [23:0] total_q, total_n;

	logic [15:0] idle_inc;
	logic [8:0]  start_inc, retry_inc;
	logic        start_fail, retry_fail;
	logic [10:0] size;
	logic [10:0] count_inc;
	logic        range_bad;
	res_t        r0, r1;
	logic [1:0]  n;

	assign advance    = valid_s1 && space;
	assign item.ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			func_s1 <= item.func;
			byte_s1 <= item.rx_byte;
		end
	end

	assign idle_inc   = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
	assign start_inc  = {1'b0, start_q} + 9'd1;
	assign retry_inc  = {1'b0, retry_q} + 9'd1;
	assign start_fail = start_inc > {1'b0, cfg.start_attempts};
	assign retry_fail = retry_inc > {1'b0, cfg.retry_limit};
	assign size       = long_q ? LONG_BYTES : SHORT_BYTES;
	assign count_inc  = count_q + 11'd1;
	assign range_bad  = ({1'b0, total_q} + {14'd0, size}) > {1'b0, cfg.image_limit};

	always_comb begin
		phase_n    = phase_q;
		started_n  = started_q;
		expected_n = expected_q;
		block_n    = block_q;
		long_n     = long_q;
		count_n    = count_q;
		crc_n      = crc_q;
		crch_n     = crch_q;
		idle_n     = idle_q;
		start_n    = start_q;
		retry_n    = retry_q;
		total_n    = total_q;
		r0         = '0;
		r1         = '0;
		n          = 2'd0;

		if (func_s1 == FN_START) begin
			phase_n    = PH_HEADER;
			started_n  = 1'b0;
			expected_n = 8'd1;
			block_n    = '0;
			long_n     = 1'b0;
			count_n    = '0;
			crc_n      = '0;
			crch_n     = '0;
			idle_n     = '0;
			start_n    = '0;
			retry_n    = '0;
			total_n    = '0;
		end else if (phase_q == PH_DONE) begin
			n = 2'd0;
		end else if (func_s1 == FN_WFAIL) begin
			r0.send_valid = 1'b1;
			r0.send_byte  = B_CAN;
			r1.send_valid = 1'b1;
			r1.send_byte  = B_CAN;
			r1.done_res   = 1'b1;
			r1.status     = ST_WFAIL;
			n             = 2'd2;
			phase_n       = PH_DONE;
		end else if (func_s1 == FN_TICK) begin
			idle_n = idle_inc;
			unique case (phase_q)
				PH_HEADER: begin
					if (idle_inc >= cfg.byte_timeout_ms) begin
						idle_n = '0;
						n      = 2'd1;
						if (!started_q) begin
							if (start_fail) begin
								r0.done_res = 1'b1;
								r0.status   = ST_START;
								phase_n     = PH_DONE;
							end else begin
								start_n       = start_inc[7:0];
								r0.send_valid = 1'b1;
								r0.send_byte  = B_C;
							end
						end else if (retry_fail) begin
							r0.done_res = 1'b1;
							r0.status   = ST_RETRY;
							phase_n     = PH_DONE;
						end else begin
							retry_n       = retry_inc[7:0];
							r0.send_valid = 1'b1;
							r0.send_byte  = B_NAK;
						end
					end
				end
				PH_DRAIN: begin
					if (idle_inc >= cfg.quiet_ms) begin
						idle_n = '0;
						n      = 2'd1;
						if (retry_fail) begin
							r0.done_res = 1'b1;
							r0.status   = ST_RETRY;
							phase_n     = PH_DONE;
						end else begin
							phase_n       = PH_HEADER;
							retry_n       = retry_inc[7:0];
							r0.send_valid = 1'b1;
							r0.send_byte  = B_NAK;
						end
					end
				end
				PH_BLK, PH_NBLK, PH_DATA, PH_CRCH, PH_CRCL: begin
					if (idle_inc >= cfg.byte_timeout_ms) begin
						idle_n  = '0;
						phase_n = PH_DRAIN;
					end
				end
				default: ;
			endcase
		end else begin
			idle_n = '0;
			unique case (phase_q)
				PH_HEADER: begin
					if (byte_s1 == B_EOT) begin
						r0.send_valid = 1'b1;
						r0.send_byte  = B_ACK;
						r0.done_res   = 1'b1;
						r0.status     = ST_OK;
						n             = 2'd1;
						phase_n       = PH_DONE;
					end else if (byte_s1 == B_CAN) begin
						r0.done_res = 1'b1;
						r0.status   = ST_CANCEL;
						n           = 2'd1;
						phase_n     = PH_DONE;
					end else if (byte_s1 == B_SOH || byte_s1 == B_STX) begin
						long_n  = (byte_s1 == B_STX);
						phase_n = PH_BLK;
					end
				end
				PH_BLK: begin
					block_n = byte_s1;
					phase_n = PH_NBLK;
				end
				PH_NBLK: begin
					if (block_q + byte_s1 == 8'hFF) begin
						count_n = '0;
						crc_n   = '0;
						phase_n = PH_DATA;
					end else begin
						phase_n = PH_DRAIN;
					end
				end
				PH_DATA: begin
					r0.data_valid = 1'b1;
					r0.data_byte  = byte_s1;
					r0.data_index = count_q[9:0];
					n             = 2'd1;
					crc_n         = crc_byte(crc_q, byte_s1);
					count_n       = count_inc;
					if (count_inc >= size) begin
						phase_n = PH_CRCH;
					end
				end
				PH_CRCH: begin
					crch_n  = byte_s1;
					phase_n = PH_CRCL;
				end
				PH_CRCL: begin
					if (crc_q != {crch_q, byte_s1}) begin
						phase_n = PH_DRAIN;
					end else if (block_q == expected_q && !range_bad) begin
						r0.send_valid   = 1'b1;
						r0.send_byte    = B_ACK;
						r0.block_good   = 1'b1;
						r0.image_offset = total_q;
						r0.block_bytes  = size;
						n               = 2'd1;
						total_n         = total_q + {13'd0, size};
						expected_n      = expected_q + 8'd1;
						started_n       = 1'b1;
						retry_n         = '0;
						phase_n         = PH_HEADER;
					end else if (block_q == expected_q - 8'd1 && block_q != expected_q) begin
						r0.send_valid = 1'b1;
						r0.send_byte  = B_ACK;
						n             = 2'd1;
						phase_n       = PH_HEADER;
					end else begin
						r0.send_valid = 1'b1;
						r0.send_byte  = B_CAN;
						r1.send_valid = 1'b1;
						r1.send_byte  = B_CAN;
						r1.done_res   = 1'b1;
						r1.status     = ST_ORDER;
						n             = 2'd2;
						phase_n       = PH_DONE;
					end
				end
				default: ;
			endcase
		end

		if (n == 2'd1) begin
			r0.last = 1'b1;
		end else if (n == 2'd2) begin
			r1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			started_q  <= 1'b0;
			expected_q <= 8'd1;
			block_q    <= '0;
			long_q     <= 1'b0;
			count_q    <= '0;
			crc_q      <= '0;
			crch_q     <= '0;
			idle_q     <= '0;
			start_q    <= '0;
			retry_q    <= '0;
			total_q    <= '0;
		end else if (advance) begin
			phase_q    <= phase_n;
			started_q  <= started_n;
			expected_q <= expected_n;
			block_q    <= block_n;
			long_q     <= long_n;
			count_q    <= count_n;
			crc_q      <= crc_n;
			crch_q     <= crch_n;
			idle_q     <= idle_n;
			start_q    <= start_n;
			retry_q    <= retry_n;
			total_q    <= total_n;
		end
	end

	assign push.count = advance ? n : 2'd0;
	assign push.r0    = r0;
	assign push.r1    = r1;

endmodule

`default_nettype wire

[rtl/core/xcrc_resq.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC result queue
// Four-entry queue taking up to two results a cycle, one out per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_resq
	import xcrc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  push_t      push,
	output logic       space,
	xcrc_res_if.source result
);

	res_t       mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;
	res_t       head;

	assign pop   = result.valid && result.ready;
	assign space = cnt_q <= 3'd2;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem[wr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.count;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push.count} - {2'b0, pop};
		end
	end

	assign head = mem[rd_q];

	assign result.valid        = cnt_q != 3'd0;
	assign result.send_valid   = head.send_valid;
	assign result.send_byte    = head.send_byte;
	assign result.data_valid   = head.data_valid;
	assign result.data_byte    = head.data_byte;
	assign result.data_index   = head.data_index;
	assign result.block_good   = head.block_good;
	assign result.image_offset = head.image_offset;
	assign result.block_bytes  = head.block_bytes;
	assign result.done_res     = head.done_res;
	assign result.status       = head.status;
	assign result.last         = head.last;

endmodule

`default_nettype wire

[rtl/core/xmodem_crc_receiver.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver
// Packet parser, CRC check and reply generation for an XMODEM-CRC download.
// ----------------------------------------------------------------------------
// Items (received bytes, millisecond ticks, session start, write-failure
// reports) enter through a registered input stage and are processed from
// that register; their results are pushed into a four-entry queue and leave
// from its head. An item that yields at most one result can follow every
// cycle while the results are taken; a cancel pair fills two queue
// entries, and the queue's free space (room for two results) sets when
// the next item is taken. Configuration may be written only while idle.
`default_nettype none

module xmodem_crc_receiver
	import xcrc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	xcrc_in_if.sink                    item,
	xcrc_res_if.source                 result
);

	cfg_t  cfg;
	push_t push;
	logic  space;

	xcrc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	xcrc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.space  (space),
		.push   (push)
	);

	xcrc_resq u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.space  (space),
		.result (result)
	);

endmodule

`default_nettype wire

[rtl/core/xcrc_check.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xcrc_check
	import xcrc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic        send_valid,
	input wire logic [7:0]  send_byte,
	input wire logic        data_valid,
	input wire logic [7:0]  data_byte,
	input wire logic        block_good,
	input wire logic [10:0] block_bytes,
	input wire logic        done_res,
	input wire logic        last
);

	// a stalled transfer keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(send_byte)
			&& $stable(last) && $stable(data_byte))
		else $error("result changed while stalled");

	a_commit: assert property (@(posedge clk) disable iff (!arst_n)
		valid && block_good |-> send_valid && send_byte == B_ACK
			&& (block_bytes == SHORT_BYTES || block_bytes == LONG_BYTES))
		else $error("block commit without ACK or with bad size");

	a_data_alone: assert property (@(posedge clk) disable iff (!arst_n)
		valid && data_valid |-> last && !send_valid && !done_res)
		else $error("payload result mixed with other results");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && done_res |-> last)
		else $error("session end not on last result");

endmodule

bind xmodem_crc_receiver xcrc_check u_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.valid       (result.valid),
	.ready       (result.ready),
	.send_valid  (result.send_valid),
	.send_byte   (result.send_byte),
	.data_valid  (result.data_valid),
	.data_byte   (result.data_byte),
	.block_good  (result.block_good),
	.block_bytes (result.block_bytes),
	.done_res    (result.done_res),
	.last        (result.last)
);

`default_nettype wire

[dv/xmodem_crc_receiver_tb.sv]
// ----------------------------------------------------------------------------
// XMODEM-CRC receiver testbench
// Drives bytes, ticks, session starts and write-failure reports with random
// gaps. Every transfer runs through an in-bench protocol predictor, and every
// reply is checked field by field in order. A short fixed table comes first.
// The random part follows, mostly whole packets, under several register
// settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xmodem_crc_receiver_tb;
	import xcrc_pkg::*;

	localparam int PHASE_ITEMS   = 140;
	localparam int NUM_PHASES    = 5;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_AFTER    = 150;
	localparam int HOLD_CYCLES   = 400;
	localparam int WDOG_LIMIT    = 2000;
	localparam res_t NO_REPLY    = '0;

	typedef struct packed {
		logic [1:0] f;
		logic [7:0] b;
		logic       typed;
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	xcrc_in_if  item_if ();
	xcrc_res_if res_if ();

	xmodem_crc_receiver DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_if),
		.result    (res_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// register mirror
	logic [23:0] lim_r;
	logic [15:0] tmo_r, quiet_r;
	logic [7:0]  satt_r, rlim_r;

	// protocol state
	phase_t      ph;
	logic        started;
	logic [7:0]  exp_blk, blk_no;
	logic        long_blk;
	logic [10:0] pay_cnt;
	logic [15:0] crc_acc;
	logic [7:0]  crc_hi;
	logic [15:0] idle_ms;
	logic [7:0]  start_cnt, retry_cnt;
	logic [23:0] img_total;

	res_t step_out[2];
	int   step_n;
	res_t reply_q[$];

	int mismatches   = 0;
	int replies_seen = 0;
	int items_fed    = 0;
	int stall_cycles = 0;
	bit send_rush    = 1'b0;
	bit take_rush    = 1'b0;

	stim_row_t plan[$];

	function automatic logic [15:0] crc16_upd(logic [15:0] c, logic [7:0] d);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ d[i];
			c = {c[14:0], 1'b0};
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	function automatic void clear_session();
		ph        = PH_HEADER;
		started   = 1'b0;
		exp_blk   = 8'd1;
		blk_no    = 8'd0;
		long_blk  = 1'b0;
		pay_cnt   = '0;
		crc_acc   = '0;
		crc_hi    = '0;
		idle_ms   = '0;
		start_cnt = '0;
		retry_cnt = '0;
		img_total = '0;
	endfunction

	function automatic void push_reply(logic [7:0] code);
		step_out[step_n] = '0;
		step_out[step_n].send_valid = 1'b1;
		step_out[step_n].send_byte = code;
		step_n++;
	endfunction

	function automatic void close_session(logic [2:0] st);
		if (step_n == 0) begin
			step_out[0] = '0;
			step_n = 1;
		end
		step_out[step_n-1].done_res = 1'b1;
		step_out[step_n-1].status = st;
		ph = PH_DONE;
	endfunction

	function automatic void cancel_pair(logic [2:0] st);
		push_reply(B_CAN);
		push_reply(B_CAN);
		close_session(st);
	endfunction

	function automatic void nak_or_give_up();
		if (9'(retry_cnt) + 9'd1 > 9'(rlim_r)) begin
			close_session(ST_RETRY);
		end else begin
			retry_cnt++;
			push_reply(B_NAK);
		end
	endfunction

	function automatic void tick_step();
		if (idle_ms != 16'hFFFF)
			idle_ms++;
		case (ph)
			PH_HEADER: begin
				if (idle_ms >= tmo_r) begin
					idle_ms = '0;
					if (started) begin
						nak_or_give_up();
					end else if (9'(start_cnt) + 9'd1 > 9'(satt_r)) begin
						close_session(ST_START);
					end else begin
						start_cnt++;
						push_reply(B_C);
					end
				end
			end
			PH_DRAIN: begin
				if (idle_ms >= quiet_r) begin
					idle_ms = '0;
					ph = PH_HEADER;
					nak_or_give_up();
				end
			end
			PH_BLK, PH_NBLK, PH_DATA, PH_CRCH, PH_CRCL: begin
				if (idle_ms >= tmo_r) begin
					idle_ms = '0;
					ph = PH_DRAIN;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void byte_step(logic [7:0] b);
		logic [10:0] size;
		logic [24:0] sum;
		size = long_blk ? LONG_BYTES : SHORT_BYTES;
		sum = {1'b0, img_total} + 25'(size);
		idle_ms = '0;
		case (ph)
			PH_HEADER: begin
				if (b == B_EOT) begin
					push_reply(B_ACK);
					close_session(ST_OK);
				end else if (b == B_CAN) begin
					close_session(ST_CANCEL);
				end else if (b == B_SOH || b == B_STX) begin
					long_blk = (b == B_STX);
					ph = PH_BLK;
				end
			end
			PH_BLK: begin
				blk_no = b;
				ph = PH_NBLK;
			end
			PH_NBLK: begin
				if (8'(blk_no + b) == 8'hFF) begin
					pay_cnt = '0;
					crc_acc = '0;
					ph = PH_DATA;
				end else begin
					ph = PH_DRAIN;
				end
			end
			PH_DATA: begin
				step_out[step_n] = '0;
				step_out[step_n].data_valid = 1'b1;
				step_out[step_n].data_byte = b;
				step_out[step_n].data_index = pay_cnt[9:0];
				step_n++;
				crc_acc = crc16_upd(crc_acc, b);
				pay_cnt++;
				if (pay_cnt >= size)
					ph = PH_CRCH;
			end
			PH_CRCH: begin
				crc_hi = b;
				ph = PH_CRCL;
			end
			PH_CRCL: begin
				if (crc_acc != {crc_hi, b}) begin
					ph = PH_DRAIN;
				end else if (blk_no == exp_blk) begin
					if (sum > 25'(lim_r)) begin
						cancel_pair(ST_ORDER);
					end else begin
						push_reply(B_ACK);
						step_out[step_n-1].block_good = 1'b1;
						step_out[step_n-1].image_offset = img_total;
						step_out[step_n-1].block_bytes = size;
						img_total = sum[23:0];
						exp_blk++;
						started = 1'b1;
						retry_cnt = '0;
						ph = PH_HEADER;
					end
				end else if (blk_no == 8'(exp_blk - 8'd1)) begin
					push_reply(B_ACK);
					ph = PH_HEADER;
				end else begin
					cancel_pair(ST_ORDER);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void predict_replies(logic [1:0] f, logic [7:0] b);
		step_n = 0;
		step_out[0] = '0;
		step_out[1] = '0;
		if (f == FN_START) begin
			clear_session();
			return;
		end
		if (ph == PH_DONE)
			return;
		case (f)
			FN_BYTE: byte_step(b);
			FN_TICK: tick_step();
			default: cancel_pair(ST_WFAIL);
		endcase
		if (step_n > 0)
			step_out[step_n-1].last = 1'b1;
	endfunction

	function automatic res_t reply(logic sv, logic [7:0] code, logic dn, logic [2:0] st,
		logic lst);
		res_t r;
		r = '0;
		r.send_valid = sv;
		r.send_byte = code;
		r.done_res = dn;
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	function automatic stim_row_t open_row(logic [1:0] f, logic [7:0] b);
		return '{f: f, b: b, typed: 1'b0, n: 2'd0, r0: NO_REPLY, r1: NO_REPLY};
	endfunction

	function automatic stim_row_t fixed_row(logic [1:0] f, logic [7:0] b, logic [1:0] n,
		res_t r0, res_t r1);
		return '{f: f, b: b, typed: 1'b1, n: n, r0: r0, r1: r1};
	endfunction

	task automatic offer(logic [1:0] f, logic [7:0] b);
		int gap;
		gap = send_rush ? 0 : $urandom_range(0, 17);
		if ($urandom_range(0, 39) == 0)
			send_rush = !send_rush;
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.func <= f;
		item_if.rx_byte <= b;
		do @(posedge clk); while (!item_if.ready);
	endtask

	task automatic feed(logic [1:0] f, logic [7:0] b, bit bulk = 1'b0);
		bit ignored;
		ignored = (ph == PH_DONE) && (f != FN_START);
		offer(f, b);
		predict_replies(f, b);
		for (int i = 0; i < step_n; i++)
			reply_q.push_back(step_out[i]);
		if (!ignored && !bulk)
			items_fed++;
	endtask

	task automatic settle();
		item_if.valid <= 1'b0;
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_regs(logic [23:0] lim, logic [15:0] tmo, logic [15:0] q,
		logic [7:0] sa, logic [7:0] rl);
		write_reg(CFG_IMAGE_LIMIT, lim);
		write_reg(CFG_BYTE_TMO, 24'(tmo));
		write_reg(CFG_QUIET, 24'(q));
		write_reg(CFG_START_ATT, 24'(sa));
		write_reg(CFG_RETRY_LIM, 24'(rl));
		cfg_we <= 1'b0;
		@(posedge clk);
		lim_r = lim;
		tmo_r = tmo;
		quiet_r = q;
		satt_r = sa;
		rlim_r = rl;
	endtask

	task automatic tick_burst();
		int span;
		span = (tmo_r < 12 ? int'(tmo_r) : 12) + (quiet_r < 12 ? int'(quiet_r) : 12) + 2;
		repeat ($urandom_range(1, span)) feed(FN_TICK, 8'($urandom));
	endtask

	// long packets are always well formed so their payload gets through
	task automatic send_packet(bit long_pkt);
		logic [7:0]  frame[$];
		logic [7:0]  blk, d;
		logic [15:0] crc;
		int          size, pick, cut;
		bit          broken;
		size = long_pkt ? 1024 : 128;
		pick = long_pkt ? 0 : $urandom_range(0, 99);
		if (pick < 70)
			blk = exp_blk;
		else if (pick < 85)
			blk = 8'(exp_blk - 8'd1);
		else
			blk = 8'($urandom);
		frame.push_back(long_pkt ? B_STX : B_SOH);
		frame.push_back(blk);
		frame.push_back(pick >= 93 ? ~blk ^ (8'd1 << $urandom_range(0, 7)) : ~blk);
		crc = '0;
		repeat (size) begin
			d = 8'($urandom);
			frame.push_back(d);
			crc = crc16_upd(crc, d);
		end
		if (!long_pkt && $urandom_range(0, 9) == 0)
			crc = crc ^ (16'd1 << $urandom_range(0, 15));
		frame.push_back(crc[15:8]);
		frame.push_back(crc[7:0]);
		broken = !long_pkt && $urandom_range(0, 19) == 0;
		if (broken) begin
			cut = $urandom_range(1, frame.size() - 1);
			while (frame.size() > cut)
				void'(frame.pop_back());
		end
		foreach (frame[i])
			feed(FN_BYTE, frame[i], long_pkt);
		if (broken || ph == PH_DRAIN || $urandom_range(0, 1) == 1)
			tick_burst();
	endtask

	task automatic run_phase(int k);
		int goal, pick;
		settle();
		case (k % 5)
			0: set_regs(24'hFF_FFFF, 16'd3, 16'd2, 8'd3, 8'd2);
			1: set_regs('0, '0, '0, '0, '0);
			2: set_regs(24'hFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
			3: set_regs(24'd384, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)),
				8'($urandom_range(1, 4)), 8'($urandom_range(0, 3)));
			default: set_regs(24'($urandom_range(0, 2048)), 16'($urandom_range(0, 8)),
				16'($urandom_range(0, 8)), 8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)));
		endcase
		goal = items_fed + PHASE_ITEMS;
		feed(FN_START, 8'($urandom));
		if (k == 0)
			send_packet(1'b1);
		while (items_fed < goal) begin
			pick = $urandom_range(0, 99);
			if (ph == PH_DONE) begin
				if (pick < 20)
					feed(2'($urandom), 8'($urandom));
				else
					feed(FN_START, 8'($urandom));
			end else if (pick < 55) begin
				send_packet(1'b0);
			end else if (pick < 70) begin
				tick_burst();
			end else if (pick < 80) begin
				feed(FN_BYTE, 8'($urandom));
			end else if (pick < 83) begin
				feed(FN_BYTE, B_EOT);
			end else if (pick < 85) begin
				feed(FN_BYTE, B_CAN);
			end else if (pick < 87) begin
				feed(FN_WFAIL, 8'($urandom));
			end else if (pick < 90) begin
				feed(FN_START, 8'($urandom));
			end else begin
				feed(2'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_IMAGE_LIMIT;
		cfg_wdata <= '0;
		item_if.valid <= 1'b0;
		item_if.func <= FN_BYTE;
		item_if.rx_byte <= '0;
		lim_r = RST_IMAGE_LIMIT;
		tmo_r = RST_BYTE_TMO;
		quiet_r = RST_QUIET;
		satt_r = RST_START_ATT;
		rlim_r = RST_RETRY_LIM;
		clear_session();

		// one-ms timeouts and single attempts so every case is a few transfers away
		plan = '{
			fixed_row(FN_TICK, 8'h00, 2'd1, reply(1'b1, B_C, 1'b0, ST_OK, 1'b1), NO_REPLY),
			fixed_row(FN_TICK, 8'h00, 2'd1, reply(1'b0, 8'h00, 1'b1, ST_START, 1'b1),
				NO_REPLY),
			fixed_row(FN_BYTE, B_SOH, 2'd0, NO_REPLY, NO_REPLY),
			fixed_row(FN_START, 8'hFF, 2'd0, NO_REPLY, NO_REPLY),
			fixed_row(FN_WFAIL, 8'hA5, 2'd2, reply(1'b1, B_CAN, 1'b0, ST_OK, 1'b0),
				reply(1'b1, B_CAN, 1'b1, ST_WFAIL, 1'b1)),
			fixed_row(FN_START, 8'h00, 2'd0, NO_REPLY, NO_REPLY),
			open_row(FN_BYTE, 8'hFF),
			fixed_row(FN_BYTE, B_CAN, 2'd1, reply(1'b0, 8'h00, 1'b1, ST_CANCEL, 1'b1),
				NO_REPLY),
			fixed_row(FN_START, 8'h00, 2'd0, NO_REPLY, NO_REPLY),
			fixed_row(FN_BYTE, B_EOT, 2'd1, reply(1'b1, B_ACK, 1'b1, ST_OK, 1'b1),
				NO_REPLY),
			fixed_row(FN_START, 8'h00, 2'd0, NO_REPLY, NO_REPLY),
			open_row(FN_BYTE, B_SOH),
			open_row(FN_BYTE, 8'h01),
			open_row(FN_BYTE, 8'h00),
			fixed_row(FN_TICK, 8'h00, 2'd1, reply(1'b1, B_NAK, 1'b0, ST_OK, 1'b1),
				NO_REPLY),
			open_row(FN_BYTE, B_STX),
			open_row(FN_BYTE, 8'h05),
			open_row(FN_BYTE, 8'hFA),
			open_row(FN_BYTE, 8'h00),
			open_row(FN_BYTE, 8'hFF),
			open_row(FN_TICK, 8'h00),
			fixed_row(FN_TICK, 8'h00, 2'd1, reply(1'b0, 8'h00, 1'b1, ST_RETRY, 1'b1),
				NO_REPLY),
			fixed_row(FN_START, 8'h00, 2'd0, NO_REPLY, NO_REPLY),
			open_row(FN_TICK, 8'h00),
			open_row(FN_TICK, 8'h00)
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_regs(RST_IMAGE_LIMIT, 16'd1, 16'd1, 8'd1, 8'd1);

		foreach (plan[i]) begin
			offer(plan[i].f, plan[i].b);
			predict_replies(plan[i].f, plan[i].b);
			if (!plan[i].typed) begin
				for (int j = 0; j < step_n; j++)
					reply_q.push_back(step_out[j]);
			end else begin
				if (plan[i].n > 0)
					reply_q.push_back(plan[i].r0);
				if (plan[i].n > 1)
					reply_q.push_back(plan[i].r1);
			end
		end

		for (int k = 0; k < NUM_PHASES; k++)
			run_phase(k);

		settle();
		if (mismatches == 0)
			$display("xmodem_crc_receiver_tb: done, clean");
		else
			$display("xmodem_crc_receiver_tb: done, errors");
		$finish;
	end

	// reply side, with one long hold-off to back the block up
	initial begin : take_proc
		int gap;
		bit held;
		held = 1'b0;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = take_rush ? 0 : $urandom_range(0, 17);
			if ($urandom_range(0, 39) == 0)
				take_rush = !take_rush;
			if (!held && replies_seen >= HOLD_AFTER) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_proc
		res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			replies_seen++;
			if (reply_q.size() == 0) begin
				$error("unexpected reply transfer: send %0b/%0h data %0b/%0h done %0b",
					res_if.send_valid, res_if.send_byte, res_if.data_valid,
					res_if.data_byte, res_if.done_res);
				mismatches++;
			end else begin
				want = reply_q.pop_front();
				check_field("send_valid", 32'(want.send_valid), 32'(res_if.send_valid));
				check_field("send_byte", 32'(want.send_byte), 32'(res_if.send_byte));
				check_field("data_valid", 32'(want.data_valid), 32'(res_if.data_valid));
				check_field("data_byte", 32'(want.data_byte), 32'(res_if.data_byte));
				check_field("data_index", 32'(want.data_index), 32'(res_if.data_index));
				check_field("block_good", 32'(want.block_good), 32'(res_if.block_good));
				check_field("image_offset", 32'(want.image_offset),
					32'(res_if.image_offset));
				check_field("block_bytes", 32'(want.block_bytes), 32'(res_if.block_bytes));
				check_field("done_res", 32'(want.done_res), 32'(res_if.done_res));
				check_field("status", 32'(want.status), 32'(res_if.status));
				check_field("last", 32'(want.last), 32'(res_if.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WDOG_LIMIT) begin
				$display("xmodem_crc_receiver_tb: done, errors");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

endmodule

[sim.f]
rtl/core/xcrc_pkg.sv
rtl/core/xcrc_if.sv
rtl/core/xcrc_cfg.sv
rtl/core/xcrc_core.sv
rtl/core/xcrc_resq.sv
rtl/core/xmodem_crc_receiver.sv
rtl/core/xcrc_check.sv
dv/xmodem_crc_receiver_tb.sv
